// ===== hdl/lru_key_value_cache_core_defines.svh =====
// ---------------------------------------------------------------------------
// LRU key/value cache assertion macros
// Shared concurrent assertion helpers for the cache RTL.
// ---------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LKVC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define LKVC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== hdl/lkvc_pkg.sv =====
// ---------------------------------------------------------------------------
// LRU key/value cache package
// Types and constants shared by the cache cells and the top level.
// ---------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;
    localparam int APB_W = 32;
    localparam int ADDR_W = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // register index as decoded from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } t_opcode;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== hdl/lkvc_cell.sv =====
// ---------------------------------------------------------------------------
// LRU cache cell
// One recency slot: compares its key, passes the match chain on, and takes
// the entry of its upper neighbour when the row shifts.
// ---------------------------------------------------------------------------
`default_nettype none

module lkvc_cell (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  lkvc_pkg::t_cell_ctl        i_ctl,
    input  wire  [lkvc_pkg::KEY_W-1:0] i_lookup_key,
    input  wire  [lkvc_pkg::KEY_W-1:0] i_prev_key,
    input  wire  [lkvc_pkg::VAL_W-1:0] i_prev_value,
    input  wire                        i_prev_valid,
    input  wire                        i_seen,
    output logic [lkvc_pkg::KEY_W-1:0] o_key,
    output logic [lkvc_pkg::VAL_W-1:0] o_value,
    output logic                       o_valid,
    output logic                       o_match,
    output logic                       o_seen,
    output logic [lkvc_pkg::VAL_W-1:0] o_sel_value
);
    import lkvc_pkg::*;

    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_value;
    logic             r_valid;

    always_comb begin
        o_match     = r_valid && (r_key == i_lookup_key);
        o_seen      = i_seen | o_match;
        o_sel_value = (o_match && !i_seen) ? r_value : '0;
        o_key       = r_key;
        o_value     = r_value;
        o_valid     = r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_valid <= i_prev_valid;
        end else if (i_ctl.clear) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_key   <= i_prev_key;
            r_value <= i_prev_value;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lru_key_value_cache_core.sv =====
// Result: registered, presented in the cycle after the request is accepted.
// Throughput: one request per cycle while the result word is not stalled; the parallel
// key compare and the first-match chain along the row of cells set the cycle time.
// Reset (synchronous, active low): all entries invalid, count zero,
// capacity 16, output register empty. No clearing pass is needed.
// ---------------------------------------------------------------------------
// LRU key/value cache core
// Fully associative store kept in recency order in a row of shifting cells.
// ---------------------------------------------------------------------------
`default_nettype none
`include "lru_key_value_cache_core_defines.svh"

module lru_key_value_cache_core #(
    parameter int ENTRIES = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire                          i_opcode,
    input  wire  [lkvc_pkg::KEY_W-1:0]   i_lookup_key,
    input  wire  [lkvc_pkg::VAL_W-1:0]   i_write_value,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic                         o_hit,
    output logic [lkvc_pkg::VAL_W-1:0]   o_read_value,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [lkvc_pkg::ADDR_W-1:0]  paddr,
    input  wire  [lkvc_pkg::APB_W-1:0]   pwdata,
    output logic [lkvc_pkg::APB_W-1:0]   prdata,
    output logic                         pready
);
    import lkvc_pkg::*;

    localparam int CW = $clog2(ENTRIES + 1);
    localparam int EW = (CW > CAP_W) ? CW : CAP_W;

    logic [CAP_W-1:0] r_capacity;
    logic [CW-1:0]    r_count, n_count;
    logic             r_out_valid;
    logic             r_out_hit;
    logic [VAL_W-1:0] r_out_value;

    logic             in_acc;
    logic             is_put;
    logic             any_hit;
    logic [VAL_W-1:0] hit_value;
    logic [CW-1:0]    cap_eff;
    logic [CW-1:0]    keep_n;
    logic [VAL_W-1:0] head_value;

    logic [KEY_W-1:0] key_vec   [ENTRIES];
    logic [VAL_W-1:0] value_vec [ENTRIES];
    logic [VAL_W-1:0] sel_vec   [ENTRIES];
    logic [ENTRIES-1:0] valid_vec;
    logic [ENTRIES-1:0] match_vec;
    logic [ENTRIES-1:0] seen_vec;
    t_cell_ctl          ctl_vec [ENTRIES];

    assign pready     = 1'b1;
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign is_put     = (t_opcode'(i_opcode) == OP_PUT);
    assign any_hit    = seen_vec[ENTRIES-1];

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_CAPACITY) begin
            prdata = {{(APB_W-CAP_W){1'b0}}, r_capacity};
        end
    end

    always_comb begin
        hit_value = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit_value = hit_value | sel_vec[i];
        end
    end

    always_comb begin
        if (r_capacity == '0) begin
            cap_eff = CW'(1);
        end else if (EW'(r_capacity) > EW'(ENTRIES)) begin
            cap_eff = CW'(ENTRIES);
        end else begin
            cap_eff = CW'(r_capacity);
        end
        keep_n     = (r_count >= cap_eff) ? (cap_eff - CW'(1)) : r_count;
        head_value = is_put ? i_write_value : hit_value;
        n_count    = (in_acc && is_put && !any_hit) ? (keep_n + CW'(1)) : r_count;
    end

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            logic [KEY_W-1:0] prev_key;
            logic [VAL_W-1:0] prev_value;
            logic             prev_valid;
            logic             prev_seen;

            if (g == 0) begin : g_head
                assign prev_key   = i_lookup_key;
                assign prev_value = head_value;
                assign prev_valid = 1'b1;
                assign prev_seen  = 1'b0;
            end else begin : g_body
                assign prev_key   = key_vec[g-1];
                assign prev_value = value_vec[g-1];
                assign prev_valid = valid_vec[g-1];
                assign prev_seen  = seen_vec[g-1];
            end

            always_comb begin
                ctl_vec[g].shift = in_acc && (any_hit ? !prev_seen
                                                      : (is_put && (CW'(g) <= keep_n)));
                ctl_vec[g].clear = in_acc && !any_hit && is_put && (CW'(g) > keep_n);
            end

            lkvc_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (ctl_vec[g]),
                .i_lookup_key (i_lookup_key),
                .i_prev_key   (prev_key),
                .i_prev_value (prev_value),
                .i_prev_valid (prev_valid),
                .i_seen       (prev_seen),
                .o_key        (key_vec[g]),
                .o_value      (value_vec[g]),
                .o_valid      (valid_vec[g]),
                .o_match      (match_vec[g]),
                .o_seen       (seen_vec[g]),
                .o_sel_value  (sel_vec[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= CAP_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY)) begin
                r_capacity <= pwdata[CAP_W-1:0];
            end
            r_count <= n_count;
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_hit   <= any_hit;
            r_out_value <= (any_hit && !is_put) ? hit_value : '0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hit        = r_out_hit;
    assign o_read_value = r_out_value;

    `LKVC_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(ENTRIES))
    `LKVC_ASSERT_IMPLY(a_valid_count, i_clk, i_rst_n, 1'b1,
                       $countones(valid_vec) == int'(r_count))
    `LKVC_ASSERT_IMPLY(a_unique_keys, i_clk, i_rst_n, 1'b1, $onehot0(match_vec))
    `LKVC_ASSERT_NEXT(a_put_fills_head, i_clk, i_rst_n, in_acc && is_put,
                      valid_vec[0] && (key_vec[0] == $past(i_lookup_key)))

endmodule

`default_nettype wire

// ===== test/lru_cache_checker.sv =====
// ---------------------------------------------------------------------------
// LRU key/value cache checker
// Watches the request, result and register channels of the cache core. It
// keeps its own recency-ordered copy of the store, works out the hit flag
// and read value of every accepted request, and compares each accepted
// result word with the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module lru_cache_checker (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    input  wire                          i_in_stall,
    input  wire                          i_opcode,
    input  wire  [lkvc_pkg::KEY_W-1:0]   i_lookup_key,
    input  wire  [lkvc_pkg::VAL_W-1:0]   i_write_value,
    input  wire                          i_out_valid,
    input  wire                          i_out_stall,
    input  wire                          i_hit,
    input  wire  [lkvc_pkg::VAL_W-1:0]   i_read_value,
    input  wire                          i_psel,
    input  wire                          i_penable,
    input  wire                          i_pwrite,
    input  wire                          i_pready,
    input  wire  [lkvc_pkg::ADDR_W-1:0]  i_paddr,
    input  wire  [lkvc_pkg::APB_W-1:0]   i_pwdata,
    output int                           o_mismatches,
    output int                           o_pending
);
    import lkvc_pkg::*;

    localparam int SLOTS = 16;

    typedef struct {
        logic             hit;
        logic [VAL_W-1:0] value;
    } t_lookup_result;

    t_lookup_result   expected_lookups[$];
    logic [KEY_W-1:0] slot_key[SLOTS];
    logic [VAL_W-1:0] slot_value[SLOTS];
    int               occupancy;
    logic [CAP_W-1:0] capacity_reg;

    initial begin
        o_mismatches = 0;
        o_pending = 0;
        occupancy = 0;
        capacity_reg = CAP_RESET;
    end

    function automatic int usable_slots(input logic [CAP_W-1:0] cap);
        if (cap == '0)
            return 1;
        if (cap > SLOTS)
            return SLOTS;
        return int'(cap);
    endfunction

    // move slots 0..depth-1 down by one and place the entry at the front
    task automatic promote(input int depth, input logic [KEY_W-1:0] key,
                           input logic [VAL_W-1:0] value);
        for (int i = depth; i > 0; i--) begin
            slot_key[i] = slot_key[i-1];
            slot_value[i] = slot_value[i-1];
        end
        slot_key[0] = key;
        slot_value[0] = value;
    endtask

    task automatic apply_request(input t_opcode op, input logic [KEY_W-1:0] key,
                                 input logic [VAL_W-1:0] wval,
                                 output t_lookup_result res);
        int               found;
        int               keep;
        logic [VAL_W-1:0] stored;
        found = -1;
        for (int i = 0; i < occupancy; i++) begin
            if (found < 0 && slot_key[i] == key)
                found = i;
        end
        res.hit = (found >= 0);
        res.value = '0;
        if (found >= 0) begin
            stored = slot_value[found];
            if (op == OP_GET)
                res.value = stored;
            promote(found, key, (op == OP_PUT) ? wval : stored);
        end else if (op == OP_PUT) begin
            keep = occupancy;
            if (keep >= usable_slots(capacity_reg))
                keep = usable_slots(capacity_reg) - 1;
            promote(keep, key, wval);
            occupancy = keep + 1;
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        o_mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_lookup_result want;
        t_lookup_result got;
        if (!i_rst_n) begin
            expected_lookups.delete();
            occupancy = 0;
            capacity_reg = CAP_RESET;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_lookups.size() == 0) begin
                    report_mismatch("result word with no request outstanding");
                end else begin
                    want = expected_lookups.pop_front();
                    if (i_hit !== want.hit)
                        report_mismatch($sformatf("hit %b, want %b", i_hit, want.hit));
                    if (i_read_value !== want.value)
                        report_mismatch($sformatf("read_value %h, want %h",
                                                  i_read_value, want.value));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                apply_request(t_opcode'(i_opcode), i_lookup_key, i_write_value, got);
                expected_lookups.push_back(got);
            end
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr[ADDR_W-1:2] == REG_CAPACITY)
                capacity_reg = i_pwdata[CAP_W-1:0];
        end
        o_pending = expected_lookups.size();
    end

endmodule

// ===== test/testbench.sv =====
// ---------------------------------------------------------------------------
// LRU key/value cache testbench
// Drives get and put requests into the cache core with random idle and
// stall bursts, reprograms the capacity between phases, and leaves all
// prediction and comparison to the checker instantiated beside the core.
// ---------------------------------------------------------------------------
module testbench;
    import lkvc_pkg::*;

    localparam logic [ADDR_W-1:0] ADDR_CAPACITY = ADDR_W'(0);
    localparam logic [ADDR_W-1:0] ADDR_UNMAPPED = ADDR_W'(4);
    localparam int                PAD_W = APB_W - CAP_W;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              opcode = OP_GET;
    logic [KEY_W-1:0]  lookup_key = '0;
    logic [VAL_W-1:0]  write_value = '0;
    logic              out_stall = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [APB_W-1:0]  pwdata = '0;

    wire               in_stall;
    wire               out_valid;
    wire               hit;
    wire [VAL_W-1:0]   read_value;
    wire [APB_W-1:0]   prdata;
    wire               pready;
    int                mismatches;
    int                pending;

    int                idle_pct = 0;
    int                stall_left = 0;
    logic [KEY_W-1:0]  key_pool[20];
    int                pool_size;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    lru_key_value_cache_core dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_opcode(opcode), .i_lookup_key(lookup_key), .i_write_value(write_value),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_hit(hit), .o_read_value(read_value),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    lru_cache_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_opcode(opcode), .i_lookup_key(lookup_key), .i_write_value(write_value),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_hit(hit), .i_read_value(read_value),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_mismatches(mismatches), .o_pending(pending)
    );

    // raise stall in random bursts while idle_pct is nonzero
    always @(posedge clk) begin
        if (idle_pct == 0) begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(99) < idle_pct) begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 6);
        end else begin
            out_stall <= 1'b0;
        end
    end

    task automatic issue_request(input t_opcode op, input logic [KEY_W-1:0] key,
                                 input logic [VAL_W-1:0] value);
        in_valid <= 1'b1;
        opcode <= op;
        lookup_key <= key;
        write_value <= value;
        do @(posedge clk); while (in_stall);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic program_register(input logic [ADDR_W-1:0] addr,
                                    input logic [APB_W-1:0] data);
        drain_results();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial begin
        int cap;
        int eff;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue_request(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        issue_request(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        issue_request(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        issue_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
        issue_request(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue_request(OP_PUT, 32'h0000_0000, 32'h1234_5678);
        issue_request(OP_GET, 32'h0000_0000, 32'hA5A5_A5A5);
        issue_request(OP_GET, 32'h0000_0005, 32'h5A5A_5A5A);
        for (int k = 1; k <= 4; k++)
            issue_request(OP_PUT, KEY_W'(k), VAL_W'(k * 32'h1111_1111));

        // shrink below the current occupancy
        program_register(ADDR_CAPACITY, 32'd2);
        issue_request(OP_GET, 32'h0000_0001, 32'h0);
        issue_request(OP_PUT, 32'h0000_0064, 32'hDEAD_BEEF);
        issue_request(OP_GET, 32'h0000_0000, 32'h0);
        issue_request(OP_GET, 32'h0000_0064, 32'h0);

        program_register(ADDR_UNMAPPED, 32'd1);
        program_register(ADDR_CAPACITY, 32'd0);
        issue_request(OP_PUT, 32'h0000_00C8, 32'h0BAD_F00D);
        issue_request(OP_PUT, 32'h0000_00C9, 32'hCAFE_0001);
        issue_request(OP_GET, 32'h0000_00C8, 32'h0);
        issue_request(OP_GET, 32'h0000_00C9, 32'h0);

        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: cap = 16;
                1: cap = 1;
                2: cap = 31;
                3: cap = 5;
                4: cap = 0;
                5: cap = 17;
                6: cap = 2;
                8: cap = $urandom_range(31);
                default: cap = $urandom_range(1, 16);
            endcase
            idle_pct = 0;
            program_register(ADDR_CAPACITY, {PAD_W'($urandom()), CAP_W'(cap)});
            eff = (cap == 0) ? 1 : ((cap > 16) ? 16 : cap);
            pool_size = eff + $urandom_range(1, 4);
            for (int k = 0; k < pool_size; k++)
                key_pool[k] = $urandom();
            case (ph % 3)
                0: idle_pct = 0;
                1: idle_pct = 25;
                default: idle_pct = 60;
            endcase
            if (ph == 9)
                idle_pct = 0;
            for (int n = 0; n < 50; n++) begin
                if ($urandom_range(9) == 0)
                    issue_request(t_opcode'($urandom_range(1)), $urandom(), $urandom());
                else
                    issue_request(t_opcode'($urandom_range(1)),
                                  key_pool[$urandom_range(pool_size - 1)], $urandom());
            end
        end

        drain_results();
        repeat (4) @(posedge clk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
